// ----- rtl/column_char_space_segmenter_defines.svh -----
// ----------------------------------------------------------------------------
// Column character/space segmenter assertion macros
// Shared concurrent assertion forms; expect clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef COLUMN_CHAR_SPACE_SEGMENTER_DEFINES_SVH
`define COLUMN_CHAR_SPACE_SEGMENTER_DEFINES_SVH

// Same-cycle implication.
`define CCS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CCS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/ccs_pkg.sv -----
// ----------------------------------------------------------------------------
// ccs_pkg
// Types, constants and helpers for the column character/space segmenter.
// ----------------------------------------------------------------------------
package ccs_pkg;

  localparam int MAX_COLUMNS = 4096;
  localparam int COL_W       = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int OUT_COL_W   = 12;
  localparam int GAP_CFG_W   = 12;
  localparam int DIST_W      = ((COL_W > GAP_CFG_W) ? COL_W : GAP_CFG_W) + 1;
  localparam int CFG_IDX_W   = 1;

  localparam int CMD_DEPTH   = 2;
  localparam int CMD_PTR_W   = $clog2(CMD_DEPTH);
  localparam int CMD_CNT_W   = $clog2(CMD_DEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] CFG_GAP_LOW  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP_HIGH = 1'b1;

  localparam logic KIND_CHAR  = 1'b0;
  localparam logic KIND_SPACE = 1'b1;

  typedef logic [COL_W-1:0] col_t;

  typedef struct packed {
    logic column_ink;
    logic last_column;
  } in_item_t;

  typedef struct packed {
    logic                 item_kind;
    logic [OUT_COL_W-1:0] start_col;
    logic [OUT_COL_W-1:0] end_col;
    logic                 last_result;
  } out_item_t;

  // One column's worth of results; slot0 is always used.
  typedef struct packed {
    out_item_t slot0;
    logic      slot1_vld;
    out_item_t slot1;
  } cmd_t;

  function automatic logic [OUT_COL_W-1:0] to_out_col(input col_t c);
    logic [31:0] ext;
    ext = 32'(c);
    return ext[OUT_COL_W-1:0];
  endfunction

  function automatic out_item_t mk_item(input logic kind, input col_t s, input col_t e);
    out_item_t it;
    it.item_kind   = kind;
    it.start_col   = to_out_col(s);
    it.end_col     = to_out_col(e);
    it.last_result = 1'b0;
    return it;
  endfunction

endpackage

// ----- rtl/ccs_front.sv -----
// ----------------------------------------------------------------------------
// ccs_front
// Column tracker: keeps line state, measures gaps and builds result commands.
// ----------------------------------------------------------------------------
module ccs_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              accept,
  input  ccs_pkg::in_item_t                 in_item,
  input  logic                              cfg_we,
  input  logic [ccs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ccs_pkg::GAP_CFG_W-1:0]     cfg_data,
  output logic                              cmd_push,
  output ccs_pkg::cmd_t                     cmd
);
  import ccs_pkg::*;

  logic [GAP_CFG_W-1:0] gap_low_r, gap_low_nxt;
  logic [GAP_CFG_W-1:0] gap_high_r, gap_high_nxt;
  col_t col_r, col_nxt;
  col_t run_start_r, run_start_nxt;
  col_t prev_end_r, prev_end_nxt;
  logic in_run_r, in_run_nxt;
  logic seen_r, seen_nxt;

  logic              ink, last;
  logic              close_prev, open_run, is_space, close_final;
  col_t              end_prev, run_start_mid, gap;
  logic [COL_W:0]    diff;
  logic [DIST_W-1:0] dl, du, low_ext, high_ext, gap_ext;

  assign ink  = in_item.column_ink;
  assign last = in_item.last_column;

  always_comb begin
    end_prev = (col_r == '0) ? COL_W'(MAX_COLUMNS - 1) : col_r - 1'b1;
    diff     = {1'b0, col_r} - {1'b0, prev_end_r} - (COL_W + 1)'(1);
    if (diff[COL_W]) begin
      gap = COL_W'(diff + (COL_W + 1)'(MAX_COLUMNS));
    end else begin
      gap = diff[COL_W-1:0];
    end
    gap_ext  = DIST_W'(gap);
    low_ext  = DIST_W'(gap_low_r);
    high_ext = DIST_W'(gap_high_r);
    dl = (low_ext >= gap_ext) ? low_ext - gap_ext : gap_ext - low_ext;
    du = (high_ext >= gap_ext) ? high_ext - gap_ext : gap_ext - high_ext;

    close_prev    = !ink && in_run_r;
    open_run      = ink && !in_run_r;
    is_space      = open_run && seen_r && (du < dl);
    run_start_mid = open_run ? col_r : run_start_r;
    close_final   = last && ink;
  end

  always_comb begin
    cmd.slot1_vld = is_space && close_final;
    cmd.slot1     = mk_item(KIND_CHAR, run_start_mid, col_r);
    if (close_prev) begin
      cmd.slot0 = mk_item(KIND_CHAR, run_start_r, end_prev);
    end else if (is_space) begin
      cmd.slot0 = mk_item(KIND_SPACE, col_r, '0);
    end else begin
      cmd.slot0 = mk_item(KIND_CHAR, run_start_mid, col_r);
    end
    cmd_push = accept && (close_prev || is_space || close_final);
  end

  always_comb begin
    gap_low_nxt   = gap_low_r;
    gap_high_nxt  = gap_high_r;
    col_nxt       = col_r;
    run_start_nxt = run_start_r;
    prev_end_nxt  = prev_end_r;
    in_run_nxt    = in_run_r;
    seen_nxt      = seen_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_GAP_LOW:  gap_low_nxt  = cfg_data;
        CFG_GAP_HIGH: gap_high_nxt = cfg_data;
        default: ;
      endcase
    end
    if (accept) begin
      if (last) begin
        col_nxt       = '0;
        run_start_nxt = '0;
        prev_end_nxt  = '0;
        in_run_nxt    = 1'b0;
        seen_nxt      = 1'b0;
      end else begin
        col_nxt       = (col_r == COL_W'(MAX_COLUMNS - 1)) ? '0 : col_r + 1'b1;
        run_start_nxt = run_start_mid;
        prev_end_nxt  = close_prev ? end_prev : prev_end_r;
        in_run_nxt    = ink;
        seen_nxt      = seen_r || open_run;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_low_r   <= '0;
      gap_high_r  <= '0;
      col_r       <= '0;
      run_start_r <= '0;
      prev_end_r  <= '0;
      in_run_r    <= 1'b0;
      seen_r      <= 1'b0;
    end else begin
      gap_low_r   <= gap_low_nxt;
      gap_high_r  <= gap_high_nxt;
      col_r       <= col_nxt;
      run_start_r <= run_start_nxt;
      prev_end_r  <= prev_end_nxt;
      in_run_r    <= in_run_nxt;
      seen_r      <= seen_nxt;
    end
  end

endmodule

// ----- rtl/ccs_cmd_fifo.sv -----
// ----------------------------------------------------------------------------
// ccs_cmd_fifo
// Short command queue between the column tracker and the result emitter.
// ----------------------------------------------------------------------------
module ccs_cmd_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  ccs_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output ccs_pkg::cmd_t head
);
  import ccs_pkg::*;

  `include "column_char_space_segmenter_defines.svh"

  cmd_t                 mem_r [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CMD_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CMD_CNT_W-1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == CMD_CNT_W'(CMD_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  `CCS_ASSERT_IMP(a_no_overflow, push, !full, "command pushed into full queue")
  `CCS_ASSERT_IMP(a_no_underflow, pop, not_empty, "command popped from empty queue")
  `CCS_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_r <= CMD_CNT_W'(CMD_DEPTH), "queue count out of range")
  `CCS_ASSERT_NXT(a_push_lands, push && !pop, not_empty, "pushed command not visible")

endmodule

// ----- rtl/ccs_back.sv -----
// ----------------------------------------------------------------------------
// ccs_back
// Result emitter: unpacks queued commands into single results.
// ----------------------------------------------------------------------------
module ccs_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cmd_vld,
  input  ccs_pkg::cmd_t       cmd,
  output logic                cmd_pop,
  output logic                out_empty,
  input  logic                out_pop,
  output ccs_pkg::out_item_t  out_item
);
  import ccs_pkg::*;

  logic      out_vld_r, out_vld_nxt;
  out_item_t out_item_r, out_item_nxt;
  logic      sel_r, sel_nxt;
  logic      load;

  assign out_empty = !out_vld_r;
  assign out_item  = out_item_r;
  assign load      = !out_vld_r || out_pop;

  always_comb begin
    out_vld_nxt  = out_vld_r;
    out_item_nxt = out_item_r;
    sel_nxt      = sel_r;
    cmd_pop      = 1'b0;
    if (load) begin
      out_vld_nxt = cmd_vld;
      if (cmd_vld) begin
        if (sel_r) begin
          out_item_nxt             = cmd.slot1;
          out_item_nxt.last_result = 1'b1;
          sel_nxt                  = 1'b0;
          cmd_pop                  = 1'b1;
        end else begin
          out_item_nxt             = cmd.slot0;
          out_item_nxt.last_result = !cmd.slot1_vld;
          sel_nxt                  = cmd.slot1_vld;
          cmd_pop                  = !cmd.slot1_vld;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      sel_r     <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
      sel_r     <= sel_nxt;
    end
  end

endmodule

// ----- rtl/column_char_space_segmenter.sv -----
// ----------------------------------------------------------------------------
// column_char_space_segmenter
// Splits a text line, one column per transfer, into characters and spaces.
// ----------------------------------------------------------------------------
// Input queue port: in_push/in_full, one column (ink flag, last-column flag)
// per transfer. Result queue port: out_empty/out_pop; the oldest result sits
// on out_item while out_empty is low. A column yields zero, one or two
// results; last_result marks the final one of each column.
// Config port: cfg_valid/cfg_ready (always ready), cfg_index 0 = narrow gap,
// 1 = wide gap. Write only while the block is idle.
// A result passes through the command queue and then the result register.
// Throughput: one column per cycle while in_full is low, limited by the
// single result register, which a column with two results occupies once
// per result. A two-entry command queue sits between column tracking and
// result output, so columns keep flowing while the receiver stalls until
// that queue is full; in_full then holds off input. Synchronous reset
// clears line state, gap widths, the queue and the result register.
// ----------------------------------------------------------------------------
module column_char_space_segmenter (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_push,
  output logic                              in_full,
  input  ccs_pkg::in_item_t                 in_item,
  output logic                              out_empty,
  input  logic                              out_pop,
  output ccs_pkg::out_item_t                out_item,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ccs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ccs_pkg::GAP_CFG_W-1:0]     cfg_data
);
  import ccs_pkg::*;

  logic accept;
  logic cmd_push, cmd_pop, cmd_vld, fifo_full;
  cmd_t push_cmd, head_cmd;

  assign cfg_ready = 1'b1;
  assign in_full   = fifo_full;
  assign accept    = in_push && !fifo_full;

  ccs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_item   (in_item),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd_push  (cmd_push),
    .cmd       (push_cmd)
  );

  ccs_cmd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cmd_push),
    .push_cmd  (push_cmd),
    .full      (fifo_full),
    .pop       (cmd_pop),
    .not_empty (cmd_vld),
    .head      (head_cmd)
  );

  ccs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_vld   (cmd_vld),
    .cmd       (head_cmd),
    .cmd_pop   (cmd_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

endmodule
